/* design/mrm_pkg.sv */
// shared constants, types and codes for the message ring mailbox
`default_nettype none

package mrm_pkg;

    // ring geometry
    localparam int RING_DEPTH    = 32;
    localparam int PAYLOAD_WORDS = 8;
    localparam int PTR_W         = $clog2(RING_DEPTH);
    localparam int CAP_W         = $clog2(RING_DEPTH + 1);

    // message field widths
    localparam int TYPE_W = 32;
    localparam int SIZE_W = 7;
    localparam int WORD_W = 64;

    // one stored message: type, size, payload words, lowest field first
    localparam int SIZE_LSB = TYPE_W;
    localparam int W0_LSB   = TYPE_W + SIZE_W;
    localparam int ROW_W    = TYPE_W + SIZE_W + PAYLOAD_WORDS * WORD_W;
    localparam int TDATA_W  = ((ROW_W + 7) / 8) * 8;
    localparam int MUSER_W  = 3;

    // size limits in bytes
    localparam logic [SIZE_W-1:0] MAX_SIZE  = SIZE_W'(PAYLOAD_WORDS * 8);
    localparam logic [SIZE_W-1:0] BELL_SIZE = SIZE_W'(8);

    // capacity register
    localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(RING_DEPTH);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 3;
    localparam logic [ADDR_W-3:0] CAP_REG_IDX = '0;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    wr_en;
        logic    rd_en;
        logic    load_now;
        logic    load_read;
        logic    ring_bell;
        status_t code;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_recv;
        logic size_bad;
        logic fits_bell;
        logic full;
        logic empty;
    } dp_status_t;

endpackage

`default_nettype wire

/* design/mrm_ctrl.sv */
// request sequencer for the message ring mailbox
`default_nettype none

module mrm_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire mrm_pkg::dp_status_t st,
    output mrm_pkg::cmd_t           cmd
);

    mrm_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrm_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mrm_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (st.is_recv && !st.empty) begin
                        state_next = mrm_pkg::S_READ;
                    end else begin
                        state_next = mrm_pkg::S_RESP;
                    end
                end
            end
            mrm_pkg::S_READ: begin
                state_next = mrm_pkg::S_RESP;
            end
            mrm_pkg::S_RESP: begin
                if (m_tready) begin
                    state_next = mrm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mrm_pkg::S_IDLE;
            end
        endcase
    end

    // commands and handshake outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            mrm_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (st.is_recv) begin
                        if (st.empty) begin
                            cmd.load_now = 1'b1;
                            cmd.code     = mrm_pkg::ST_EMPTY;
                        end else begin
                            cmd.rd_en = 1'b1;
                        end
                    end else if (st.size_bad) begin
                        cmd.load_now = 1'b1;
                        cmd.code     = mrm_pkg::ST_INVALID;
                    end else if (st.full) begin
                        cmd.load_now = 1'b1;
                        cmd.code     = mrm_pkg::ST_FULL;
                    end else begin
                        cmd.wr_en     = 1'b1;
                        cmd.load_now  = 1'b1;
                        cmd.code      = mrm_pkg::ST_OK;
                        cmd.ring_bell = st.fits_bell;
                    end
                end
            end
            mrm_pkg::S_READ: begin
                cmd.load_read = 1'b1;
            end
            mrm_pkg::S_RESP: begin
                m_tvalid = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/mrm_datapath.sv */
// pointers, capacity, ring memory and result register of the mailbox
`default_nettype none

module mrm_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [mrm_pkg::TDATA_W-1:0]       s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [mrm_pkg::CAP_W-1:0]         cfg_wdata,
    output logic      [mrm_pkg::CAP_W-1:0]         cap,
    input  wire mrm_pkg::cmd_t                     cmd,
    output mrm_pkg::dp_status_t                    st,
    output logic      [mrm_pkg::TDATA_W-1:0]       m_tdata,
    output logic      [mrm_pkg::MUSER_W-1:0]       m_tuser
);

    logic [mrm_pkg::CAP_W-1:0]   cap_reg;
    logic [mrm_pkg::PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [mrm_pkg::PTR_W-1:0]   wr_ptr_adv, rd_ptr_adv;
    logic [mrm_pkg::ROW_W-1:0]   ring_mem [mrm_pkg::RING_DEPTH];
    logic [mrm_pkg::ROW_W-1:0]   rd_row_reg;
    logic [mrm_pkg::TDATA_W-1:0] out_data_reg, out_data_next;
    logic [mrm_pkg::MUSER_W-1:0] out_user_reg, out_user_next;
    logic [mrm_pkg::SIZE_W-1:0]  in_size;

    // step a pointer, wrapping at the active capacity
    function automatic logic [mrm_pkg::PTR_W-1:0] advance(
        input logic [mrm_pkg::PTR_W-1:0] p,
        input logic [mrm_pkg::CAP_W-1:0] c
    );
        logic [mrm_pkg::CAP_W-1:0] n;
        n = mrm_pkg::CAP_W'(p) + mrm_pkg::CAP_W'(1);
        return (n >= c) ? '0 : n[mrm_pkg::PTR_W-1:0];
    endfunction

    // limit a written capacity to the supported range
    function automatic logic [mrm_pkg::CAP_W-1:0] clamp_cap(
        input logic [mrm_pkg::CAP_W-1:0] v
    );
        logic [mrm_pkg::CAP_W-1:0] r;
        r = v;
        if (v < mrm_pkg::CAP_MIN) begin
            r = mrm_pkg::CAP_MIN;
        end
        if (v > mrm_pkg::CAP_MAX) begin
            r = mrm_pkg::CAP_MAX;
        end
        return r;
    endfunction

    assign wr_ptr_adv = advance(wr_ptr_reg, cap_reg);
    assign rd_ptr_adv = advance(rd_ptr_reg, cap_reg);
    assign in_size    = s_tdata[mrm_pkg::SIZE_LSB +: mrm_pkg::SIZE_W];

    // status toward the controller
    assign st.is_recv   = s_tuser;
    assign st.size_bad  = (in_size > mrm_pkg::MAX_SIZE);
    assign st.fits_bell = (in_size <= mrm_pkg::BELL_SIZE);
    assign st.full      = (wr_ptr_adv == rd_ptr_reg);
    assign st.empty     = (wr_ptr_reg == rd_ptr_reg);

    // capacity register and ring pointers; a capacity write empties the ring
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= mrm_pkg::CAP_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else if (cfg_we) begin
            cap_reg    <= clamp_cap(cfg_wdata);
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (cmd.wr_en) begin
                wr_ptr_reg <= wr_ptr_adv;
            end
            if (cmd.rd_en) begin
                rd_ptr_reg <= rd_ptr_adv;
            end
        end
    end

    // ring memory, one message per row, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            ring_mem[wr_ptr_reg] <= s_tdata[mrm_pkg::ROW_W-1:0];
        end
        if (cmd.rd_en) begin
            rd_row_reg <= ring_mem[rd_ptr_reg];
        end
    end

    // result loading
    always_comb begin
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        if (cmd.load_now) begin
            out_data_next = '0;
            if (cmd.ring_bell) begin
                out_data_next[mrm_pkg::W0_LSB +: mrm_pkg::WORD_W] =
                    s_tdata[mrm_pkg::W0_LSB +: mrm_pkg::WORD_W];
            end
            out_user_next = {cmd.ring_bell, cmd.code};
        end else if (cmd.load_read) begin
            out_data_next = mrm_pkg::TDATA_W'(rd_row_reg);
            out_user_next = {1'b0, mrm_pkg::ST_OK};
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;
    assign cap     = cap_reg;

endmodule

`default_nettype wire

/* design/message_ring_mailbox.sv */
// message ring mailbox top level: stream channels, register port, checks
//
//  channel  | ports              | carries
//  ---------+--------------------+----------------------------------------------
//  request  | s_tvalid/s_tready  | s_tuser: req_type; s_tdata: msg, size, words
//  result   | m_tvalid/m_tready  | m_tuser: status, doorbell; m_tdata: message
//  config   | psel/penable/...   | ring_capacity at byte address 0
//
// one request is in flight at a time. a send or a failed request goes through accept,
// then result; a successful receive goes through accept, ring read, then result, as the
// ring memory has a registered read port.
// a stalled result holds the block until m_tready; no new request is taken meanwhile.
// synchronous active-low reset empties the ring and sets the capacity to 32.
`default_nettype none

module message_ring_mailbox (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // request: tuser = req_type
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic                                 s_tuser,
    // message tag, byte size, payload words 0 .. 7, zero pad
    input  wire logic [mrm_pkg::TDATA_W-1:0]          s_tdata,
    // result
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // status, doorbell
    output logic      [mrm_pkg::MUSER_W-1:0]          m_tuser,
    // received tag, received size, payload words 0 .. 7, zero pad
    output logic      [mrm_pkg::TDATA_W-1:0]          m_tdata,
    // register port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mrm_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [mrm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic      [mrm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                      pready
);

    mrm_pkg::cmd_t             cmd;
    mrm_pkg::dp_status_t       st;
    logic                      cap_sel;
    logic                      cfg_we;
    logic [mrm_pkg::CAP_W-1:0] cap;

    // register decode
    assign cap_sel = (paddr[mrm_pkg::ADDR_W-1:2] == mrm_pkg::CAP_REG_IDX);
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready && cap_sel;
    assign prdata  = cap_sel ? mrm_pkg::APB_DATA_W'(cap) : '0;

    mrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mrm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[mrm_pkg::CAP_W-1:0]),
        .cap       (cap),
        .cmd       (cmd),
        .st        (st),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // a capacity write leaves the ring empty
    a_cfg_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> st.empty)
        else $error("ring not empty after capacity write");

    // never ready for a request while a result is pending
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request accepted while result pending");

    // a doorbell only comes with a successful send
    a_bell_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == mrm_pkg::ST_OK))
        else $error("doorbell with failing status");

    // full and empty never hold together
    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(st.full && st.empty))
        else $error("ring reports full and empty");

    // the memory is never written and read in the same request
    a_wr_rd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_en && cmd.rd_en))
        else $error("ring write and read together");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// testbench for the message ring mailbox: directed table, random phases, self-checking
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;

    // one request as the sender sees it
    typedef struct packed {
        logic                                     is_recv;
        logic [TYPE_W-1:0]                        msg_tag;
        logic [SIZE_W-1:0]                        size;
        logic [PAYLOAD_WORDS-1:0][WORD_W-1:0]     words;
    } mbx_req_t;

    // one result as the receiver sees it
    typedef struct packed {
        status_t                                  status;
        logic                                     doorbell;
        logic [TYPE_W-1:0]                        msg_tag;
        logic [SIZE_W-1:0]                        size;
        logic [PAYLOAD_WORDS-1:0][WORD_W-1:0]     words;
    } mbx_rsp_t;

    // directed table rows
    typedef enum logic [1:0] {
        ROW_SEND,
        ROW_RECV,
        ROW_CFG
    } row_kind_t;

    // the tag carries the register value on config rows
    typedef struct packed {
        row_kind_t          kind;
        logic [TYPE_W-1:0]  tag;
        logic [SIZE_W-1:0]  size;
        logic [WORD_W-1:0]  fill;
        logic               typed;
        status_t            exp_status;
    } plan_row_t;

    localparam int PLAN_LEN = 23;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{ROW_RECV, 32'h0000_0000, 7'd0,   64'h0,                   1'b1, ST_EMPTY},
        '{ROW_SEND, 32'h0000_0000, 7'd0,   64'h0,                   1'b0, ST_OK},
        '{ROW_SEND, 32'hFFFF_FFFF, 7'd8,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_OK},
        '{ROW_SEND, 32'h0000_A5A5, 7'd9,   64'h5555_5555_5555_5555, 1'b0, ST_OK},
        '{ROW_SEND, 32'h1234_5678, 7'd64,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ST_OK},
        '{ROW_SEND, 32'h8000_0001, 7'd65,  64'h1,                   1'b1, ST_INVALID},
        '{ROW_SEND, 32'hFFFF_FFFF, 7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_INVALID},
        '{ROW_RECV, 32'h0000_0000, 7'd0,   64'h0,                   1'b0, ST_OK},
        '{ROW_RECV, 32'h0000_0000, 7'd0,   64'h0,                   1'b0, ST_OK},
        '{ROW_RECV, 32'h0000_0000, 7'd0,   64'h0,                   1'b0, ST_OK},
        '{ROW_RECV, 32'h0000_0000, 7'd0,   64'h0,                   1'b0, ST_OK},
        '{ROW_RECV, 32'h0000_0000, 7'd0,   64'h0,                   1'b1, ST_EMPTY},
        '{ROW_CFG,  32'd0,         7'd0,   64'h0,                   1'b0, ST_OK},
        '{ROW_SEND, 32'h0BAD_F00D, 7'd1,   64'h0123_4567_89AB_CDEF, 1'b0, ST_OK},
        '{ROW_SEND, 32'h0000_0003, 7'd3,   64'h3,                   1'b1, ST_FULL},
        '{ROW_RECV, 32'h0000_0000, 7'd0,   64'h0,                   1'b0, ST_OK},
        '{ROW_RECV, 32'h0000_0000, 7'd0,   64'h0,                   1'b1, ST_EMPTY},
        '{ROW_CFG,  32'd63,        7'd0,   64'h0,                   1'b0, ST_OK},
        '{ROW_SEND, 32'h7FFF_FFFF, 7'd64,  64'hFEDC_BA98_7654_3210, 1'b0, ST_OK},
        '{ROW_RECV, 32'h0000_0000, 7'd0,   64'h0,                   1'b0, ST_OK},
        '{ROW_SEND, 32'h0000_0007, 7'd7,   64'h7,                   1'b0, ST_OK},
        '{ROW_CFG,  32'd1,         7'd0,   64'h0,                   1'b0, ST_OK},
        '{ROW_RECV, 32'h0000_0000, 7'd0,   64'h0,                   1'b1, ST_EMPTY}
    };

    // random phases: capacity written, share of sends in percent
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 111;
    localparam logic [31:0] PHASE_CAP [PHASES] = '{
        32'd2, 32'd32, 32'd5, 32'd0, 32'd63, 32'd17, 32'd1, 32'hFFFF_FFC3, 32'd9
    };
    localparam int PHASE_SEND_PCT [PHASES] = '{55, 70, 30, 60, 75, 30, 50, 65, 45};

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic                     s_tuser  = 1'b0;
    // message tag, byte size, payload words 0 .. 7, zero pad
    logic [TDATA_W-1:0]       s_tdata  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // status, doorbell
    logic [MUSER_W-1:0]       m_tuser;
    // received tag, received size, payload words 0 .. 7, zero pad
    logic [TDATA_W-1:0]       m_tdata;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [ADDR_W-1:0]        paddr    = '0;
    logic [APB_DATA_W-1:0]    pwdata   = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    message_ring_mailbox dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // mailbox shadow state
    int unsigned                              ring_cap = RING_DEPTH;
    int unsigned                              head_idx = 0;
    int unsigned                              tail_idx = 0;
    logic [TYPE_W-1:0]                        slot_type  [RING_DEPTH];
    logic [SIZE_W-1:0]                        slot_size  [RING_DEPTH];
    logic [PAYLOAD_WORDS-1:0][WORD_W-1:0]     slot_words [RING_DEPTH];

    mbx_rsp_t pending_rsp [$];
    int       mismatches   = 0;
    int       src_idle_pct = 30;
    int       snk_idle_pct = 55;
    int       quiet_cycles = 0;

    function automatic int unsigned ring_next(int unsigned p);
        return (p + 1 >= ring_cap) ? 0 : p + 1;
    endfunction

    // capacity register write: low 6 bits, clamped, pointers cleared
    function automatic void shadow_set_capacity(logic [31:0] value);
        int unsigned v;
        v = value[5:0];
        if (v < 2) v = 2;
        if (v > RING_DEPTH) v = RING_DEPTH;
        ring_cap = v;
        head_idx = 0;
        tail_idx = 0;
    endfunction

    // result of one request, updating the shadow ring
    function automatic mbx_rsp_t mailbox_outcome(mbx_req_t r);
        mbx_rsp_t o;
        int unsigned nxt;
        o = '0;
        o.status = ST_OK;
        if (!r.is_recv) begin
            nxt = ring_next(head_idx);
            if (r.size > MAX_SIZE) begin
                o.status = ST_INVALID;
            end else if (nxt == tail_idx) begin
                o.status = ST_FULL;
            end else begin
                slot_type[head_idx]  = r.msg_tag;
                slot_size[head_idx]  = r.size;
                slot_words[head_idx] = r.words;
                head_idx = nxt;
                if (r.size <= BELL_SIZE) begin
                    o.doorbell = 1'b1;
                    o.words[0] = r.words[0];
                end
            end
        end else if (head_idx == tail_idx) begin
            o.status = ST_EMPTY;
        end else begin
            o.msg_tag  = slot_type[tail_idx];
            o.size     = slot_size[tail_idx];
            o.words    = slot_words[tail_idx];
            tail_idx   = ring_next(tail_idx);
        end
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
    endtask

    // result channel: compare each transaction with the oldest expectation
    always @(posedge aclk) begin
        mbx_rsp_t got;
        mbx_rsp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status   = status_t'(m_tuser[1:0]);
            got.doorbell = m_tuser[2];
            got.msg_tag  = m_tdata[0 +: TYPE_W];
            got.size     = m_tdata[SIZE_LSB +: SIZE_W];
            got.words    = m_tdata[W0_LSB +: PAYLOAD_WORDS * WORD_W];
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected result status", 64'(got.status), 64'h0);
            end else begin
                want = pending_rsp.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.doorbell != want.doorbell)
                    report_mismatch("doorbell", 64'(got.doorbell), 64'(want.doorbell));
                if (got.msg_tag != want.msg_tag)
                    report_mismatch("message tag", 64'(got.msg_tag), 64'(want.msg_tag));
                if (got.size != want.size)
                    report_mismatch("byte size", 64'(got.size), 64'(want.size));
                for (int i = 0; i < PAYLOAD_WORDS; i++)
                    if (got.words[i] != want.words[i])
                        report_mismatch($sformatf("word_out_%0d", i),
                                        got.words[i], want.words[i]);
            end
        end
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout at %0t", $realtime);
            $display("tb NOT OK");
            $finish;
        end
    end

    // present one request, wait for its transaction, record its outcome
    task automatic send_request(mbx_req_t r, logic typed, status_t typed_status);
        mbx_rsp_t o;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.is_recv;
        s_tdata  <= TDATA_W'({r.words, r.size, r.msg_tag});
        do @(posedge aclk); while (!s_tready);
        o = mailbox_outcome(r);
        // error outcomes carry only their status
        if (typed) begin
            o = '0;
            o.status = typed_status;
        end
        pending_rsp.push_back(o);
    endtask

    // drain, let the block settle, then write the capacity register
    task automatic write_capacity(logic [31:0] value);
        s_tvalid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(4 * CAP_REG_IDX);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_set_capacity(value);
    endtask

    function automatic mbx_req_t random_request(int send_pct);
        mbx_req_t r;
        int pick;
        r.is_recv  = ($urandom_range(99) >= send_pct);
        r.msg_tag  = $urandom;
        pick = $urandom_range(99);
        if (pick < 10)
            r.size = SIZE_W'($urandom_range(127, 65));
        else if (pick < 40)
            r.size = SIZE_W'($urandom_range(8));
        else
            r.size = SIZE_W'($urandom_range(64));
        for (int i = 0; i < PAYLOAD_WORDS; i++)
            r.words[i] = {$urandom, $urandom};
        return r;
    endfunction

    initial begin
        mbx_req_t r;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int n = 0; n < PLAN_LEN; n++) begin
            if (PLAN[n].kind == ROW_CFG) begin
                write_capacity(PLAN[n].tag);
            end else begin
                r.is_recv  = (PLAN[n].kind == ROW_RECV);
                r.msg_tag  = PLAN[n].tag;
                r.size     = PLAN[n].size;
                for (int i = 0; i < PAYLOAD_WORDS; i++)
                    r.words[i] = PLAN[n].fill;
                send_request(r, PLAN[n].typed, PLAN[n].exp_status);
            end
        end

        // random phases, idling pattern changes every three phases
        for (int p = 0; p < PHASES; p++) begin
            case (p / 3)
                0: begin
                    src_idle_pct = 30;
                    snk_idle_pct = 55;
                end
                1: begin
                    src_idle_pct = 55;
                    snk_idle_pct = 30;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            write_capacity((p == PHASES - 1) ? 32'($urandom_range(63)) : PHASE_CAP[p]);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_request(random_request(PHASE_SEND_PCT[p]), 1'b0, ST_OK);
        end

        // wrap up
        s_tvalid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
